// ===== rtl/vlmf_pkg.sv =====
`default_nettype none

package vlmf_pkg;

   // Store geometry
   localparam int BufBytes    = 1024;
   localparam int HeaderBytes = 8;
   localparam int AddrW       = $clog2(BufBytes);
   localparam int PosW        = AddrW + 1;
   localparam int HdrCntW     = $clog2(HeaderBytes);

   // Field widths
   localparam int CmdW    = 3;
   localparam int SizeW   = 10;
   localparam int ByteW   = 8;
   localparam int StatusW = 3;
   localparam int CountW  = 7;
   localparam int HsizeW  = 15;
   localparam int TdataW  = 32;

   // Width for space arithmetic: holds the store size and a full message span
   localparam int SpanW  = (PosW > SizeW + 1) ? PosW : SizeW + 1;
   localparam int SpaceW = SpanW + 1;

   localparam logic [CountW-1:0] CountMax = CountW'(127);
   localparam logic [ByteW-1:0]  LinkFlag = 8'h80;

   // Command codes
   localparam logic [CmdW-1:0] CMD_PUT_START = 3'd0;
   localparam logic [CmdW-1:0] CMD_PUT_DATA  = 3'd1;
   localparam logic [CmdW-1:0] CMD_PEEK      = 3'd2;
   localparam logic [CmdW-1:0] CMD_PURGE     = 3'd3;
   localparam logic [CmdW-1:0] CMD_CLEAR     = 3'd4;

   // Status codes
   localparam logic [StatusW-1:0] ST_OK         = 3'd0;
   localparam logic [StatusW-1:0] ST_NO_SPACE   = 3'd1;
   localparam logic [StatusW-1:0] ST_EMPTY      = 3'd2;
   localparam logic [StatusW-1:0] ST_BAD        = 3'd3;
   localparam logic [StatusW-1:0] ST_BAD_OFFSET = 3'd4;

   typedef struct packed {
      logic [CmdW-1:0]  cmd;
      logic [SizeW-1:0] msg_size;
      logic [ByteW-1:0] data_byte;
      logic [SizeW-1:0] byte_offset;
   } req_type;

   typedef struct packed {
      logic [StatusW-1:0] status;
      logic [ByteW-1:0]   read_byte;
      logic [SizeW-1:0]   head_size;
      logic [CountW-1:0]  msg_count;
   } rsp_type;

   typedef struct packed {
      logic             wr_en;
      logic [AddrW-1:0] wr_addr;
      logic [ByteW-1:0] wr_data;
      logic [AddrW-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

// ===== rtl/vlmf_ram.sv =====
`default_nettype none

module vlmf_ram #(
   parameter int Depth = 1024,
   parameter int Width = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/vlmf_ctrl.sv =====
`default_nettype none

module vlmf_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire vlmf_pkg::req_type          req,
   output logic                            req_ready,
   input  wire logic                       out_free,
   output logic                            rsp_valid,
   output vlmf_pkg::rsp_type               rsp,
   output vlmf_pkg::mem_req_type           mem_req,
   input  wire logic [vlmf_pkg::ByteW-1:0] rd_data
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_LINK_RD,
      S_LINK_W2,
      S_LINK_W3,
      S_HDR,
      S_PEEK_LO,
      S_PEEK_HI,
      S_PEEK_DATA,
      S_PURGE_FLAG,
      S_PURGE_LO,
      S_PURGE_HI,
      S_RESP
   } state_type;

   localparam int AddrW  = vlmf_pkg::AddrW;
   localparam int PosW   = vlmf_pkg::PosW;
   localparam int SpaceW = vlmf_pkg::SpaceW;

   state_type                        state_ff, state_in;
   vlmf_pkg::req_type                req_ff, req_in;
   logic [AddrW-1:0]                 rp_ff, rp_in;
   logic [PosW-1:0]                  wp_ff, wp_in;
   logic [vlmf_pkg::CountW-1:0]      count_ff, count_in;
   logic [AddrW-1:0]                 tail_ff, tail_in;
   logic                             tail_valid_ff, tail_valid_in;
   logic [PosW-1:0]                  fill_ff, fill_in;
   logic [vlmf_pkg::SizeW-1:0]       remain_ff, remain_in;
   logic                             active_ff, active_in;
   logic [AddrW-1:0]                 pos_ff, pos_in;
   logic [vlmf_pkg::HdrCntW-1:0]     hdr_cnt_ff, hdr_cnt_in;
   logic [vlmf_pkg::ByteW-1:0]       lo_ff, lo_in;
   logic [vlmf_pkg::StatusW-1:0]     res_status_ff, res_status_in;
   logic [vlmf_pkg::ByteW-1:0]       res_byte_ff, res_byte_in;
   logic [vlmf_pkg::SizeW-1:0]       res_hsize_ff, res_hsize_in;

   logic [SpaceW-1:0]          total;
   logic [SpaceW-1:0]          wp_ext;
   logic [SpaceW-1:0]          rp_ext;
   logic [SpaceW-1:0]          buf_ext;
   logic                       front_region;
   logic                       fit_end;
   logic                       fit_front;
   logic                       fit_gap;
   logic                       space_ok;
   logic [AddrW-1:0]           new_pos;
   logic [15:0]                pos_word;
   logic [15:0]                size_word;
   logic [vlmf_pkg::ByteW-1:0] hdr_byte;
   logic [vlmf_pkg::HsizeW-1:0] hsize_word;

   // Space check for a new message
   assign total   = SpaceW'(req_ff.msg_size) + SpaceW'(vlmf_pkg::HeaderBytes);
   assign wp_ext  = SpaceW'(wp_ff);
   assign rp_ext  = SpaceW'(rp_ff);
   assign buf_ext = SpaceW'(vlmf_pkg::BufBytes);

   assign front_region = (count_ff == '0) || (wp_ext > rp_ext);
   assign fit_end      = (wp_ext <= buf_ext) && (total <= buf_ext - wp_ext);
   assign fit_front    = total <= rp_ext;
   assign fit_gap      = (wp_ext < rp_ext) && (total <= rp_ext - wp_ext);

   always_comb begin
      space_ok = 1'b0;
      new_pos  = wp_ff[AddrW-1:0];
      if (front_region) begin
         if (fit_end) begin
            space_ok = 1'b1;
         end else if (fit_front) begin
            space_ok = 1'b1;
            new_pos  = '0;
         end
      end else if (fit_gap) begin
         space_ok = 1'b1;
      end
   end

   assign pos_word   = 16'(pos_ff);
   assign size_word  = 16'(req_ff.msg_size);
   assign hsize_word = {rd_data[6:0], lo_ff};

   // Header bytes: size, zero link, zero padding
   always_comb begin
      case (hdr_cnt_ff)
         vlmf_pkg::HdrCntW'(0): hdr_byte = size_word[7:0];
         vlmf_pkg::HdrCntW'(1): hdr_byte = size_word[15:8];
         default:               hdr_byte = '0;
      endcase
   end

   // Sequence memory accesses and update queue pointers
   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      count_in      = count_ff;
      tail_in       = tail_ff;
      tail_valid_in = tail_valid_ff;
      fill_in       = fill_ff;
      remain_in     = remain_ff;
      active_in     = active_ff;
      pos_in        = pos_ff;
      hdr_cnt_in    = hdr_cnt_ff;
      lo_in         = lo_ff;
      res_status_in = res_status_ff;
      res_byte_in   = res_byte_ff;
      res_hsize_in  = res_hsize_ff;
      mem_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in       = req;
               res_byte_in  = '0;
               res_hsize_in = '0;
               state_in     = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            state_in      = S_RESP;
            res_status_in = vlmf_pkg::ST_BAD;
            case (req_ff.cmd)
               vlmf_pkg::CMD_PUT_START: begin
                  if (req_ff.msg_size == '0 || active_ff) begin
                     res_status_in = vlmf_pkg::ST_BAD;
                  end else if (count_ff >= vlmf_pkg::CountMax || !space_ok) begin
                     res_status_in = vlmf_pkg::ST_NO_SPACE;
                  end else begin
                     pos_in     = new_pos;
                     hdr_cnt_in = '0;
                     if (tail_valid_ff) begin
                        mem_req.rd_addr = tail_ff + AddrW'(1);
                        state_in        = S_LINK_RD;
                     end else begin
                        state_in = S_HDR;
                     end
                  end
               end
               vlmf_pkg::CMD_PUT_DATA: begin
                  if (active_ff) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = fill_ff[AddrW-1:0];
                     mem_req.wr_data = req_ff.data_byte;
                     fill_in         = fill_ff + PosW'(1);
                     remain_in       = remain_ff - vlmf_pkg::SizeW'(1);
                     if (remain_ff == vlmf_pkg::SizeW'(1)) begin
                        active_in = 1'b0;
                        count_in  = count_ff + vlmf_pkg::CountW'(1);
                     end
                     res_status_in = vlmf_pkg::ST_OK;
                  end
               end
               vlmf_pkg::CMD_PEEK: begin
                  if (count_ff == '0) begin
                     res_status_in = vlmf_pkg::ST_EMPTY;
                  end else begin
                     mem_req.rd_addr = rp_ff;
                     state_in        = S_PEEK_LO;
                  end
               end
               vlmf_pkg::CMD_PURGE: begin
                  if (count_ff == '0) begin
                     res_status_in = vlmf_pkg::ST_EMPTY;
                  end else begin
                     mem_req.rd_addr = rp_ff + AddrW'(1);
                     state_in        = S_PURGE_FLAG;
                  end
               end
               vlmf_pkg::CMD_CLEAR: begin
                  rp_in         = '0;
                  wp_in         = '0;
                  count_in      = '0;
                  tail_in       = '0;
                  tail_valid_in = 1'b0;
                  fill_in       = '0;
                  remain_in     = '0;
                  active_in     = 1'b0;
                  res_status_in = vlmf_pkg::ST_OK;
               end
               default: begin
                  res_status_in = vlmf_pkg::ST_BAD;
               end
            endcase
         end

         // Set the link flag in the old tail header
         S_LINK_RD: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tail_ff + AddrW'(1);
            mem_req.wr_data = rd_data | vlmf_pkg::LinkFlag;
            state_in        = S_LINK_W2;
         end

         S_LINK_W2: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tail_ff + AddrW'(2);
            mem_req.wr_data = pos_word[7:0];
            state_in        = S_LINK_W3;
         end

         S_LINK_W3: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tail_ff + AddrW'(3);
            mem_req.wr_data = pos_word[15:8];
            state_in        = S_HDR;
         end

         // Write the new header one byte a cycle
         S_HDR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff + AddrW'(hdr_cnt_ff);
            mem_req.wr_data = hdr_byte;
            if (hdr_cnt_ff == vlmf_pkg::HdrCntW'(vlmf_pkg::HeaderBytes - 1)) begin
               tail_in       = pos_ff;
               tail_valid_in = 1'b1;
               wp_in         = PosW'(SpaceW'(pos_ff) + total);
               fill_in       = PosW'(pos_ff) + PosW'(vlmf_pkg::HeaderBytes);
               remain_in     = req_ff.msg_size;
               active_in     = 1'b1;
               res_status_in = vlmf_pkg::ST_OK;
               state_in      = S_RESP;
            end else begin
               hdr_cnt_in = hdr_cnt_ff + vlmf_pkg::HdrCntW'(1);
            end
         end

         S_PEEK_LO: begin
            lo_in           = rd_data;
            mem_req.rd_addr = rp_ff + AddrW'(1);
            state_in        = S_PEEK_HI;
         end

         S_PEEK_HI: begin
            res_hsize_in = hsize_word[vlmf_pkg::SizeW-1:0];
            if (vlmf_pkg::HsizeW'(req_ff.byte_offset) < hsize_word) begin
               mem_req.rd_addr = rp_ff + AddrW'(vlmf_pkg::HeaderBytes)
                               + AddrW'(req_ff.byte_offset);
               state_in        = S_PEEK_DATA;
            end else begin
               res_status_in = vlmf_pkg::ST_BAD_OFFSET;
               state_in      = S_RESP;
            end
         end

         S_PEEK_DATA: begin
            res_byte_in   = rd_data;
            res_status_in = vlmf_pkg::ST_OK;
            state_in      = S_RESP;
         end

         // Follow the head link, or drop to an empty queue
         S_PURGE_FLAG: begin
            count_in      = count_ff - vlmf_pkg::CountW'(1);
            res_status_in = vlmf_pkg::ST_OK;
            if ((rd_data & vlmf_pkg::LinkFlag) != '0) begin
               mem_req.rd_addr = rp_ff + AddrW'(2);
               state_in        = S_PURGE_LO;
            end else begin
               rp_in         = '0;
               wp_in         = '0;
               tail_in       = '0;
               tail_valid_in = 1'b0;
               state_in      = S_RESP;
            end
         end

         S_PURGE_LO: begin
            lo_in           = rd_data;
            mem_req.rd_addr = rp_ff + AddrW'(3);
            state_in        = S_PURGE_HI;
         end

         S_PURGE_HI: begin
            rp_in    = AddrW'({rd_data, lo_ff});
            state_in = S_RESP;
         end

         S_RESP: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Hold state and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rp_ff         <= '0;
         wp_ff         <= '0;
         count_ff      <= '0;
         tail_ff       <= '0;
         tail_valid_ff <= 1'b0;
         fill_ff       <= '0;
         remain_ff     <= '0;
         active_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         count_ff      <= count_in;
         tail_ff       <= tail_in;
         tail_valid_ff <= tail_valid_in;
         fill_ff       <= fill_in;
         remain_ff     <= remain_in;
         active_ff     <= active_in;
      end
      req_ff        <= req_in;
      pos_ff        <= pos_in;
      hdr_cnt_ff    <= hdr_cnt_in;
      lo_ff         <= lo_in;
      res_status_ff <= res_status_in;
      res_byte_ff   <= res_byte_in;
      res_hsize_ff  <= res_hsize_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = (state_ff == S_RESP);
   assign rsp.status    = res_status_ff;
   assign rsp.read_byte = res_byte_ff;
   assign rsp.head_size = res_hsize_ff;
   assign rsp.msg_count = count_ff;

endmodule

`default_nettype wire

// ===== rtl/variable_length_message_fifo_top.sv =====
// Channel  | Ports                       | tdata fields, lowest bit first
// request  | req_tvalid/tready/tdata[31:0] | cmd 3, msg_size 10, data_byte 8, byte_offset 10
// response | rsp_tvalid/tready/tdata[31:0] | status 3, read_byte 8, head_size 10, msg_count 7
//
// One command is worked at a time, from accept to response.
// The store writes through one byte-wide port: one header byte per cycle.
// The response sits in an output register; a new command is taken while it waits.
// Synchronous reset empties the queue at once; store contents are not cleared.
`default_nettype none

module variable_length_message_fifo_top (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // cmd[2:0], msg_size[12:3], data_byte[20:13], byte_offset[30:21]
   input  wire logic [vlmf_pkg::TdataW-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // status[2:0], read_byte[10:3], head_size[20:11], msg_count[27:21]
   output logic      [vlmf_pkg::TdataW-1:0] rsp_tdata
);

   vlmf_pkg::req_type          req;
   vlmf_pkg::rsp_type          ctrl_rsp;
   vlmf_pkg::mem_req_type      mem_req;
   logic                       ctrl_rsp_valid;
   logic                       out_free;
   logic [vlmf_pkg::ByteW-1:0] rd_data;
   logic                       rsp_valid_ff, rsp_valid_in;
   vlmf_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   // Unpack request beat
   assign req.cmd         = req_tdata[2:0];
   assign req.msg_size    = req_tdata[12:3];
   assign req.data_byte   = req_tdata[20:13];
   assign req.byte_offset = req_tdata[30:21];

   vlmf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req       (req),
      .req_ready (req_tready),
      .out_free  (out_free),
      .rsp_valid (ctrl_rsp_valid),
      .rsp       (ctrl_rsp),
      .mem_req   (mem_req),
      .rd_data   (rd_data)
   );

   vlmf_ram #(
      .Depth (vlmf_pkg::BufBytes),
      .Width (vlmf_pkg::ByteW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // Output register: load when empty or draining
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = ctrl_rsp_valid;
         if (ctrl_rsp_valid) begin
            rsp_data_in = ctrl_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000, rsp_data_ff.msg_count, rsp_data_ff.head_size,
                        rsp_data_ff.read_byte, rsp_data_ff.status};

`ifndef NO_ASSERTIONS
   // One command in flight: after an accept the request side closes
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while a command is in flight");

   // An empty report goes with a zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status == vlmf_pkg::ST_EMPTY)
         |-> (rsp_data_ff.msg_count == '0))
      else $error("empty status with nonzero message count");

   // A returned byte only comes with a successful peek
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.read_byte != '0)
         |-> (rsp_data_ff.status == vlmf_pkg::ST_OK))
      else $error("read byte returned with failing status");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;

   localparam int unsigned RandomItems = 1550;
   localparam int unsigned IdlePct     = 27;
   localparam int unsigned DrainEvery  = 500;
   localparam int unsigned TailCycles  = 20;
   localparam int unsigned SizeMask    = (1 << vlmf_pkg::HsizeW) - 1;
   localparam int unsigned LinkMask    = {vlmf_pkg::LinkFlag, 8'h00};
   localparam int unsigned BufBytes    = vlmf_pkg::BufBytes;
   localparam int unsigned HeaderBytes = vlmf_pkg::HeaderBytes;

   typedef logic [vlmf_pkg::CmdW-1:0] cmd_code_type;

   // Codes past clear are not defined by the block
   localparam cmd_code_type CmdFirstUnused = vlmf_pkg::CMD_CLEAR + 1'b1;
   localparam cmd_code_type CmdLastUnused  = '1;

   typedef struct {
      vlmf_pkg::req_type req;
      bit                drain;
   } queued_cmd_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic                        req_tready;
   logic [vlmf_pkg::TdataW-1:0] req_tdata  = '0;
   logic                        rsp_tvalid;
   logic                        rsp_tready = 1'b0;
   logic [vlmf_pkg::TdataW-1:0] rsp_tdata;

   queued_cmd_type    pending_cmds[$];
   vlmf_pkg::rsp_type expected_rsps[$];
   int unsigned issued_count = 0;
   int unsigned sent_count   = 0;
   int unsigned rsp_count    = 0;
   int unsigned error_count  = 0;
   bit          drain_next   = 1'b0;
   logic        calm;

   // Shadow copy of the message queue
   logic [7:0]  shadow_mem [BufBytes];
   int unsigned shadow_rd      = 0;
   int unsigned shadow_wr      = 0;
   int unsigned shadow_count   = 0;
   int unsigned shadow_tail    = 0;
   int unsigned shadow_fill    = 0;
   int unsigned shadow_left    = 0;
   bit          shadow_tail_ok = 1'b0;
   bit          shadow_filling = 1'b0;

   variable_length_message_fifo_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // No idling on either side through this stretch of beats
   assign calm = (sent_count >= 500) && (sent_count < 850);

   function automatic int unsigned mem_half(int unsigned addr);
      return {shadow_mem[(addr + 1) % BufBytes], shadow_mem[addr % BufBytes]};
   endfunction

   function automatic void set_half(int unsigned addr, int unsigned value);
      shadow_mem[addr % BufBytes]       = 8'(value);
      shadow_mem[(addr + 1) % BufBytes] = 8'(value >> 8);
   endfunction

   function automatic void empty_shadow();
      shadow_rd      = 0;
      shadow_wr      = 0;
      shadow_count   = 0;
      shadow_tail    = 0;
      shadow_fill    = 0;
      shadow_left    = 0;
      shadow_tail_ok = 1'b0;
      shadow_filling = 1'b0;
   endfunction

   // Apply one command to the shadow queue and return the response it earns
   function automatic vlmf_pkg::rsp_type apply_queue_command(vlmf_pkg::req_type r);
      vlmf_pkg::rsp_type e;
      int unsigned total;
      int unsigned pos;
      int unsigned hdr;
      bit          fits;
      e        = '0;
      e.status = vlmf_pkg::ST_BAD;
      total    = r.msg_size + HeaderBytes;
      pos      = 0;
      fits     = 1'b1;
      case (r.cmd)
         vlmf_pkg::CMD_PUT_START: begin
            if (r.msg_size == 0 || shadow_filling) begin
               e.status = vlmf_pkg::ST_BAD;
            end else if (shadow_count >= vlmf_pkg::CountMax) begin
               e.status = vlmf_pkg::ST_NO_SPACE;
            end else begin
               // Place after the write position, else at the front, else reject
               if (shadow_wr > shadow_rd || shadow_count == 0) begin
                  if (shadow_wr <= BufBytes && total <= BufBytes - shadow_wr)
                     pos = shadow_wr;
                  else if (total <= shadow_rd) pos = 0;
                  else fits = 1'b0;
               end else if (shadow_wr < shadow_rd && total <= shadow_rd - shadow_wr) begin
                  pos = shadow_wr;
               end else begin
                  fits = 1'b0;
               end
               if (!fits) begin
                  e.status = vlmf_pkg::ST_NO_SPACE;
               end else begin
                  // Link the previous tail header to the new message
                  if (shadow_tail_ok) begin
                     set_half(shadow_tail, (mem_half(shadow_tail) & SizeMask) | LinkMask);
                     set_half(shadow_tail + 2, pos);
                  end
                  shadow_tail    = pos;
                  shadow_tail_ok = 1'b1;
                  set_half(pos, r.msg_size);
                  set_half(pos + 2, 0);
                  for (int k = 4; k < HeaderBytes; k++) shadow_mem[(pos + k) % BufBytes] = '0;
                  shadow_wr      = pos + total;
                  shadow_fill    = pos + HeaderBytes;
                  shadow_left    = r.msg_size;
                  shadow_filling = 1'b1;
                  e.status       = vlmf_pkg::ST_OK;
               end
            end
         end
         vlmf_pkg::CMD_PUT_DATA: begin
            if (shadow_filling) begin
               shadow_mem[shadow_fill % BufBytes] = r.data_byte;
               shadow_fill++;
               shadow_left--;
               // Commit on the final byte
               if (shadow_left == 0) begin
                  shadow_filling = 1'b0;
                  shadow_count++;
               end
               e.status = vlmf_pkg::ST_OK;
            end
         end
         vlmf_pkg::CMD_PEEK: begin
            if (shadow_count == 0) begin
               e.status = vlmf_pkg::ST_EMPTY;
            end else begin
               hdr         = mem_half(shadow_rd) & SizeMask;
               e.head_size = vlmf_pkg::SizeW'(hdr);
               if (r.byte_offset < hdr) begin
                  e.read_byte = shadow_mem[(shadow_rd + HeaderBytes + r.byte_offset)
                                           % BufBytes];
                  e.status    = vlmf_pkg::ST_OK;
               end else begin
                  e.status = vlmf_pkg::ST_BAD_OFFSET;
               end
            end
         end
         vlmf_pkg::CMD_PURGE: begin
            if (shadow_count == 0) begin
               e.status = vlmf_pkg::ST_EMPTY;
            end else begin
               hdr = mem_half(shadow_rd);
               shadow_count--;
               // Follow the link, or reset the pointers when none follows
               if (hdr & LinkMask) begin
                  shadow_rd = mem_half(shadow_rd + 2) % BufBytes;
               end else begin
                  shadow_rd      = 0;
                  shadow_wr      = 0;
                  shadow_tail    = 0;
                  shadow_tail_ok = 1'b0;
               end
               e.status = vlmf_pkg::ST_OK;
            end
         end
         vlmf_pkg::CMD_CLEAR: begin
            empty_shadow();
            e.status = vlmf_pkg::ST_OK;
         end
         default: e.status = vlmf_pkg::ST_BAD;
      endcase
      e.msg_count = vlmf_pkg::CountW'(shadow_count);
      return e;
   endfunction

   // Queue one command for the driver along with the response it should get
   task automatic issue(cmd_code_type cmd, int unsigned size, int unsigned dbyte,
                        int unsigned offset);
      queued_cmd_type q;
      q.req.cmd         = cmd;
      q.req.msg_size    = vlmf_pkg::SizeW'(size);
      q.req.data_byte   = vlmf_pkg::ByteW'(dbyte);
      q.req.byte_offset = vlmf_pkg::SizeW'(offset);
      q.drain           = drain_next;
      drain_next        = 1'b0;
      pending_cmds.push_back(q);
      expected_rsps.push_back(apply_queue_command(q.req));
      issued_count++;
   endtask

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Drive request beats, pausing at random and before drain points
   always @(posedge clock) begin : drive
      int unsigned    sent_now;
      logic           next_valid;
      queued_cmd_type cur;
      sent_now   = sent_count;
      next_valid = req_tvalid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sent_now++;
            next_valid = 1'b0;
         end
         if (!next_valid && pending_cmds.size() != 0) begin
            if (pending_cmds[0].drain && rsp_count != sent_now) begin
               // hold until every outstanding response is back
            end else if (calm || $urandom_range(0, 99) >= IdlePct) begin
               cur        = pending_cmds.pop_front();
               req_tdata  <= vlmf_pkg::TdataW'({cur.req.byte_offset, cur.req.data_byte,
                                                cur.req.msg_size, cur.req.cmd});
               next_valid = 1'b1;
            end
         end
      end
      sent_count <= sent_now;
      req_tvalid <= next_valid;
   end

   // Take response beats and compare them with the oldest expectation
   always @(posedge clock) begin : observe
      vlmf_pkg::rsp_type got;
      vlmf_pkg::rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status    = rsp_tdata[0 +: vlmf_pkg::StatusW];
            got.read_byte = rsp_tdata[vlmf_pkg::StatusW +: vlmf_pkg::ByteW];
            got.head_size = rsp_tdata[vlmf_pkg::StatusW + vlmf_pkg::ByteW +: vlmf_pkg::SizeW];
            got.msg_count = rsp_tdata[vlmf_pkg::StatusW + vlmf_pkg::ByteW + vlmf_pkg::SizeW
                                      +: vlmf_pkg::CountW];
            if (expected_rsps.size() == 0) begin
               $error("response beat with nothing expected: %h", rsp_tdata);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("status", want.status, got.status);
               check_field("read_byte", want.read_byte, got.read_byte);
               check_field("head_size", want.head_size, got.head_size);
               check_field("msg_count", want.msg_count, got.msg_count);
            end
            rsp_count <= rsp_count + 1;
         end
         rsp_tready <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
   end

   initial begin
      int unsigned  pick;
      int unsigned  size;
      int unsigned  head_len;
      int unsigned  next_drain;
      int unsigned  last_item;
      cmd_code_type odd_cmd;

      foreach (shadow_mem[k]) shadow_mem[k] = '0;

      // Directed: empty queue, bad requests, size extremes
      issue(vlmf_pkg::CMD_PEEK, $urandom, $urandom, 0);
      issue(vlmf_pkg::CMD_PURGE, $urandom, $urandom, $urandom);
      issue(vlmf_pkg::CMD_PUT_DATA, $urandom, 8'h5a, $urandom);
      issue(vlmf_pkg::CMD_PUT_START, 0, $urandom, $urandom);
      issue(CmdFirstUnused, $urandom, $urandom, $urandom);
      issue(CmdLastUnused, $urandom, $urandom, $urandom);
      issue(vlmf_pkg::CMD_PUT_START, 1023, $urandom, $urandom);
      issue(vlmf_pkg::CMD_PUT_START, BufBytes - HeaderBytes + 1, $urandom, $urandom);
      issue(vlmf_pkg::CMD_PUT_START, BufBytes - HeaderBytes, $urandom, $urandom);
      // put while filling, then clear drops the open message
      issue(vlmf_pkg::CMD_PUT_START, 5, $urandom, $urandom);
      issue(vlmf_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
      issue(vlmf_pkg::CMD_PUT_DATA, $urandom, $urandom, $urandom);
      // small message, byte extremes, offsets in and past range
      issue(vlmf_pkg::CMD_PUT_START, 2, $urandom, $urandom);
      issue(vlmf_pkg::CMD_PUT_DATA, $urandom, 8'hff, $urandom);
      issue(vlmf_pkg::CMD_PUT_DATA, $urandom, 8'h00, $urandom);
      issue(vlmf_pkg::CMD_PEEK, $urandom, $urandom, 0);
      issue(vlmf_pkg::CMD_PEEK, $urandom, $urandom, 1);
      issue(vlmf_pkg::CMD_PEEK, $urandom, $urandom, 2);
      issue(vlmf_pkg::CMD_PEEK, $urandom, $urandom, 1023);
      // purge the head while the next message is still being filled
      issue(vlmf_pkg::CMD_PUT_START, 3, $urandom, $urandom);
      issue(vlmf_pkg::CMD_PURGE, $urandom, $urandom, $urandom);
      issue(vlmf_pkg::CMD_PEEK, $urandom, $urandom, 0);
      for (int k = 0; k < 3; k++) issue(vlmf_pkg::CMD_PUT_DATA, $urandom, $urandom, $urandom);
      issue(vlmf_pkg::CMD_PEEK, $urandom, $urandom, 2);

      // Random: mostly complete messages, with peeks, purges and some noise
      drain_next = 1'b1;
      next_drain = issued_count + DrainEvery;
      last_item  = issued_count + RandomItems;
      while (issued_count < last_item) begin
         if (issued_count >= next_drain) begin
            drain_next = 1'b1;
            next_drain += DrainEvery;
         end
         // Finish any message left open by noise
         while (shadow_filling) issue(vlmf_pkg::CMD_PUT_DATA, $urandom, $urandom, $urandom);
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            size = $urandom_range(0, 99);
            if (size < 80) size = $urandom_range(1, 16);
            else if (size < 97) size = $urandom_range(17, 96);
            else size = $urandom_range(97, 300);
            issue(vlmf_pkg::CMD_PUT_START, size, $urandom, $urandom);
            for (int k = 0; k < size && shadow_filling; k++) begin
               // Now and then break into the fill
               if ($urandom_range(0, 199) == 0) begin
                  case ($urandom_range(0, 3))
                     0: odd_cmd = vlmf_pkg::CMD_PEEK;
                     1: odd_cmd = vlmf_pkg::CMD_PURGE;
                     2: odd_cmd = vlmf_pkg::CMD_CLEAR;
                     default: odd_cmd = vlmf_pkg::CMD_PUT_START;
                  endcase
                  issue(odd_cmd, $urandom, $urandom, $urandom);
               end
               issue(vlmf_pkg::CMD_PUT_DATA, $urandom, $urandom, $urandom);
            end
         end else if (pick < 62) begin
            head_len = (shadow_count != 0) ? (mem_half(shadow_rd) & SizeMask) : 0;
            if (head_len != 0 && $urandom_range(0, 99) < 85)
               issue(vlmf_pkg::CMD_PEEK, $urandom, $urandom, $urandom_range(0, head_len - 1));
            else
               issue(vlmf_pkg::CMD_PEEK, $urandom, $urandom, $urandom);
         end else if (pick < 82) begin
            issue(vlmf_pkg::CMD_PURGE, $urandom, $urandom, $urandom);
         end else if (pick < 84) begin
            issue(vlmf_pkg::CMD_CLEAR, $urandom, $urandom, $urandom);
         end else begin
            case ($urandom_range(0, 3))
               0: issue(vlmf_pkg::CMD_PUT_DATA, $urandom, $urandom, $urandom);
               1: issue(vlmf_pkg::CMD_PUT_START, 0, $urandom, $urandom);
               2: issue(CmdLastUnused - cmd_code_type'($urandom_range(0, 2)), $urandom,
                        $urandom, $urandom);
               default: issue(cmd_code_type'($urandom), $urandom, $urandom, $urandom);
            endcase
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Let every response arrive, then watch for strays before the final check
      wait (rsp_count >= issued_count);
      repeat (TailCycles) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d expected responses never arrived", expected_rsps.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire
